// ===== hdl/interflow_routing_cell_step_macros.svh =====
// Assertion macros used by the checker of the interflow routing block.
`ifndef INTERFLOW_ROUTING_CELL_STEP_MACROS_SVH
`define INTERFLOW_ROUTING_CELL_STEP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define IRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define IRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/irc_pkg.sv =====
// Shared types and constants of the interflow routing block.
package irc_pkg;

    localparam int WORD_W        = 40;
    localparam int FRAC_BITS     = 32;
    localparam int MAX_CELLS_DEF = 65536;

    localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};
    localparam logic [WORD_W-1:0] ONE_Q    = 40'd1 << FRAC_BITS;
    localparam logic [60:0]       ONE_60   = 61'd1 << 60;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_DT_OVER_DX    = 2'd0,
        CFG_INV_CELL_SIZE = 2'd1,
        CFG_MIN_WATER     = 2'd2,
        CFG_CELL_COUNT    = 2'd3
    } t_cfg_idx;

    // One input word.
    typedef struct packed {
        logic [39:0] soil_moisture;
        logic [39:0] field_capacity;
        logic [39:0] saturation;
        logic [39:0] layer_depth;
        logic [39:0] channel_length;
        logic [39:0] conductivity;
        logic [39:0] decay_coeff;
        logic [39:0] flow_weight;
        logic [39:0] slope;
        logic [32:0] excess_share;
        logic [15:0] downstream_index;
        logic        has_downstream;
    } t_in;

    // One result word.
    typedef struct packed {
        logic [15:0] cell_index;
        logic [39:0] new_moisture;
        logic [39:0] to_channel;
        logic [39:0] to_downstream;
        logic [39:0] repercolation;
        logic        saturated_flag;
    } t_out;

endpackage

// ===== hdl/irc_mul.sv =====
// Byte-serial 64 by 64 multiplier with a full 128-bit product.
module irc_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);

    localparam logic [2:0] LAST_STEP = 3'd7;

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [71:0]  w_pp;
    logic [71:0]  w_sum;

    // One 64 by 8 partial product per cycle, added into the upper half.
    assign w_pp  = r_a * r_b[7:0];
    assign w_sum = 72'(r_acc[127:64]) + w_pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= {w_sum, r_acc[63:8]};
                r_b   <= r_b >> 8;
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== hdl/irc_div.sv =====
// Restoring divider, one quotient bit per cycle, 72-bit dividend.
module irc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [71:0] i_dividend,
    input  logic [41:0] i_divisor,
    output logic        o_done,
    output logic [71:0] o_quo
);

    localparam logic [6:0] LAST_STEP = 7'd71;

    logic [71:0] r_q;
    logic [41:0] r_r;
    logic [41:0] r_d;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [42:0] w_rs;
    logic [42:0] w_diff;
    logic        w_ge;

    // Shift in the next dividend bit and try a subtract.
    assign w_rs   = {r_r, r_q[71]};
    assign w_ge   = w_rs >= {1'b0, r_d};
    assign w_diff = w_rs - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_d    <= i_divisor;
                r_r    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_r   <= w_ge ? w_diff[41:0] : w_rs[41:0];
                r_q   <= {r_q[70:0], w_ge};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// ===== hdl/irc_sqrt.sv =====
// Digit-by-digit square root of a Q9.32 value, one root bit per cycle.
module irc_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [40:0] i_rad,
    output logic        o_done,
    output logic [36:0] o_root
);

    localparam logic [5:0] LAST_STEP = 6'd36;

    logic [73:0] r_x;
    logic [38:0] r_rem;
    logic [36:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [40:0] w_t;
    logic [40:0] w_trial;
    logic        w_ge;

    // Bring down the next bit pair and compare with 4r+1.
    assign w_t     = {r_rem, r_x[73:72]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = w_t >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= {1'b0, i_rad, 32'd0};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_ge ? 39'(w_t - w_trial) : w_t[38:0];
                r_root <= {r_root[35:0], w_ge};
                r_x    <= r_x << 2;
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hdl/interflow_routing_cell_step.sv =====
// Top level of the interflow routing block: sequencer, inflow store and shared units.
//
//   channel   direction  handshake                    word
//   in        input      i_in_valid / o_in_stall      irc_pkg::t_in
//   out       output     o_out_valid / i_out_stall    irc_pkg::t_out
//   cfg       input      i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
// A cell below the routing threshold skips the routing, with one extra multiply when the soil
// holds water above field capacity. A cell that routes spends its time in the shared multiplier
// (series terms, reciprocal scaling, twelve squarings and shares), the restoring divider (up to
// four quotients) and the square root. After reset a clearing pass zeroes the inflow store; no
// word is taken meanwhile. A stalled result waits in the output register while the next word is
// processed; the block holds at its last step until that register is free.
module interflow_routing_cell_step #(
    parameter int MAX_CELLS = irc_pkg::MAX_CELLS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  irc_pkg::t_in     i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output irc_pkg::t_out    o_out_data,
    input  logic             i_cfg_we,
    input  irc_pkg::t_cfg_idx i_cfg_idx,
    input  logic [39:0]      i_cfg_data
);

    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam logic [2:0] K_FIRST  = 3'd6;
    localparam logic [2:0] K_LAST   = 3'd1;
    localparam logic [3:0] SQR_LAST = 4'd11;
    // Rounded-up reciprocals of the series divisors in Q0.60.
    localparam logic [63:0] M_DIV3  = ((64'd1 << 60) + 64'd2) / 64'd3;
    localparam logic [63:0] M_DIV5  = ((64'd1 << 60) + 64'd4) / 64'd5;
    localparam logic [63:0] M_DIV6  = ((64'd1 << 60) + 64'd5) / 64'd6;

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_EXC, S_THRESH, S_EXP_CHK, S_HORN_MUL, S_HORN_DIV,
        S_HORN_SUB, S_SQR_MUL, S_SQR_ACC, S_CHN0, S_CHN1, S_CHN2, S_CHN3, S_CHN4,
        S_CHN5, S_CHN6, S_SIN0, S_SIN_U, S_SIN_Y, S_SIN_R, S_SIN_D, S_ALP0, S_ALP1,
        S_ALP2, S_ALP3, S_ALP4, S_ALP5, S_ALP6, S_THETA0, S_THETA1, S_SAT0, S_SAT1,
        S_SAT2, S_SAT3, S_DS0, S_DS1, S_FINISH, S_WAIT
    } t_state;

    // Saturating Q8.32 add: overflow bit over the 40-bit value.
    function automatic logic [40:0] f_addq(logic [39:0] a, logic [39:0] b);
        logic [40:0] s;
        s = 41'(a) + 41'(b);
        return s[40] ? {1'b1, irc_pkg::WORD_MAX} : s;
    endfunction

    // Reciprocal of a series divisor; the product of 54-bit terms stays exact.
    function automatic logic [63:0] f_recip(logic [2:0] k);
        logic [63:0] m;
        case (k)
            3'd1:    m = 64'd1 << 60;
            3'd2:    m = 64'd1 << 59;
            3'd3:    m = M_DIV3;
            3'd4:    m = 64'd1 << 58;
            3'd5:    m = M_DIV5;
            default: m = M_DIV6;
        endcase
        return m;
    endfunction

    t_state        r_state, n_state, r_ret, n_ret;
    irc_pkg::t_in  r_in, n_in;
    logic [32:0]   r_share, n_share;
    logic [39:0]   r_togo, n_togo, r_theta, n_theta, r_chn, n_chn;
    logic [39:0]   r_down, n_down, r_rr, n_rr, r_tmp, n_tmp;
    logic [39:0]   r_alpha, n_alpha, r_sa, n_sa;
    logic          r_flag, n_flag, r_sbig, n_sbig, r_raw, n_raw;
    logic [32:0]   r_e, n_e;
    logic [53:0]   r_t, n_t;
    logic [60:0]   r_p, n_p;
    logic [2:0]    r_k, n_k;
    logic [3:0]    r_sqn, n_sqn;
    logic [63:0]   r_ma, n_ma, r_mb, n_mb;
    logic          r_mstart, n_mstart, r_dstart, n_dstart, r_sstart, n_sstart;
    logic [71:0]   r_da, n_da;
    logic [41:0]   r_db, n_db;
    logic [40:0]   r_sy, n_sy;
    logic [AW-1:0] r_cnt, n_cnt, r_clr, n_clr;
    logic          r_ovalid, n_ovalid;
    irc_pkg::t_out r_out, n_out;
    logic [39:0]   r_dtdx, r_invcs, r_minw;
    logic [16:0]   r_ccount;

    logic [39:0]   mem [MAX_CELLS];
    logic [39:0]   r_rdq;
    logic          w_we;
    logic [AW-1:0] w_wa, w_ra;
    logic [39:0]   w_wd;

    logic          mul_done, div_done, sqrt_done;
    logic [127:0]  mul_prod;
    logic [71:0]   div_quo;
    logic [36:0]   sqrt_root;
    logic [39:0]   w_mq, w_dq;
    logic          w_mq_ovf, w_dq_ovf;
    logic [60:0]   w_pnew;
    logic [31:0]   w_ds32, w_c32, w_cinc, w_ceff;
    logic [AW-1:0] w_ds_idx, w_cnext;
    logic          w_ds_ok;
    logic [40:0]   w_add;
    logic [39:0]   w_part;

    // Shared arithmetic units.
    irc_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart), .i_a(r_ma), .i_b(r_mb),
        .o_done(mul_done), .o_prod(mul_prod)
    );
    irc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart), .i_dividend(r_da),
        .i_divisor(r_db), .o_done(div_done), .o_quo(div_quo)
    );
    irc_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_sstart), .i_rad(r_sy),
        .o_done(sqrt_done), .o_root(sqrt_root)
    );

    // Saturated views of the unit results and raw series values.
    assign w_mq_ovf = |mul_prod[127:irc_pkg::FRAC_BITS+40];
    assign w_mq     = w_mq_ovf ? irc_pkg::WORD_MAX : mul_prod[irc_pkg::FRAC_BITS +: 40];
    assign w_dq_ovf = |div_quo[71:40];
    assign w_dq     = w_dq_ovf ? irc_pkg::WORD_MAX : div_quo[39:0];
    assign w_pnew   = mul_prod[120:60];

    // Receiver index and cell counter wrap.
    assign w_ds32   = 32'(r_in.downstream_index);
    assign w_ds_idx = w_ds32[AW-1:0];
    assign w_ds_ok  = r_in.has_downstream && (w_ds32 < 32'(MAX_CELLS));
    assign w_c32    = 32'(r_cnt);
    assign w_cinc   = w_c32 + 32'd1;
    always_comb begin
        w_ceff = 32'(r_ccount);
        if (w_ceff == 32'd0) w_ceff = 32'd1;
        if (w_ceff > 32'(MAX_CELLS)) w_ceff = 32'(MAX_CELLS);
    end
    assign w_cnext = (w_cinc >= w_ceff) ? '0 : w_cinc[AW-1:0];
    assign w_part  = (irc_pkg::ONE_Q > 40'(r_e)) ? irc_pkg::ONE_Q - 40'(r_e) : '0;
    assign w_add   = f_addq(r_rdq, r_down);

    // Store write port: clearing pass, entry clear on load, receiver add.
    always_comb begin
        w_we = 1'b0;
        w_wa = r_cnt;
        w_wd = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                w_wa = r_clr;
            end
            S_LOAD:  w_we = 1'b1;
            S_DS1: begin
                w_we = 1'b1;
                w_wa = w_ds_idx;
                w_wd = w_add[39:0];
            end
            default: w_we = 1'b0;
        endcase
    end
    assign w_ra = (r_state == S_DS0) ? w_ds_idx : r_cnt;

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_wa] <= w_wd;
        r_rdq <= mem[w_ra];
    end

    // Sequencer next-state logic.
    always_comb begin
        logic [40:0] s;
        n_state = r_state;  n_ret = r_ret;    n_in = r_in;      n_share = r_share;
        n_togo = r_togo;    n_theta = r_theta; n_chn = r_chn;   n_down = r_down;
        n_rr = r_rr;        n_tmp = r_tmp;    n_alpha = r_alpha; n_sa = r_sa;
        n_flag = r_flag;    n_sbig = r_sbig;  n_raw = r_raw;    n_e = r_e;
        n_t = r_t;          n_p = r_p;        n_k = r_k;        n_sqn = r_sqn;
        n_ma = r_ma;        n_mb = r_mb;      n_da = r_da;      n_db = r_db;
        n_sy = r_sy;        n_cnt = r_cnt;    n_clr = r_clr;    n_out = r_out;
        n_mstart = 1'b0;    n_dstart = 1'b0;  n_sstart = 1'b0;
        n_ovalid = r_ovalid && i_out_stall;
        s = '0;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(MAX_CELLS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_share = (i_in_data.excess_share > 33'(irc_pkg::ONE_Q)) ?
                              33'(irc_pkg::ONE_Q) : i_in_data.excess_share;
                    n_flag  = 1'b0;
                    n_chn   = '0;
                    n_down  = '0;
                    n_rr    = '0;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_togo  = r_rdq;
                n_theta = (r_in.soil_moisture > r_in.field_capacity) ?
                          r_in.field_capacity : r_in.soil_moisture;
                if (r_in.soil_moisture > r_in.field_capacity) begin
                    n_ma = 64'(r_in.soil_moisture - r_in.field_capacity);
                    n_mb = 64'(r_in.layer_depth);
                    n_mstart = 1'b1; n_raw = 1'b0; n_ret = S_EXC; n_state = S_WAIT;
                end else begin
                    n_state = S_THRESH;
                end
            end
            S_EXC: begin
                s = f_addq(r_togo, w_mq);
                n_togo = s[39:0];
                n_flag = r_flag | s[40];
                n_state = S_THRESH;
            end
            S_THRESH: begin
                if (r_togo > r_minw) begin
                    if (r_in.channel_length != '0) begin
                        n_ma = 64'(r_in.decay_coeff);
                        n_mb = 64'(r_togo);
                        n_mstart = 1'b1; n_raw = 1'b0; n_ret = S_EXP_CHK; n_state = S_WAIT;
                    end else begin
                        n_state = S_SIN0;
                    end
                end else begin
                    n_state = S_FINISH;
                end
            end
            // Exponential: Horner series on x/4096, then twelve squarings.
            S_EXP_CHK: begin
                if (w_mq[39:38] != 2'b00) begin
                    n_e = '0;
                    n_state = S_CHN0;
                end else begin
                    n_t = {w_mq[37:0], 16'd0};
                    n_p = irc_pkg::ONE_60;
                    n_k = K_FIRST;
                    n_state = S_HORN_MUL;
                end
            end
            S_HORN_MUL: begin
                n_ma = 64'(r_t);
                n_mb = 64'(r_p);
                n_mstart = 1'b1; n_raw = 1'b1; n_ret = S_HORN_DIV; n_state = S_WAIT;
            end
            // The division by the term index is a multiply by its reciprocal.
            S_HORN_DIV: begin
                n_ma = 64'(mul_prod[113:60]);
                n_mb = f_recip(r_k);
                n_mstart = 1'b1; n_raw = 1'b1; n_ret = S_HORN_SUB; n_state = S_WAIT;
            end
            S_HORN_SUB: begin
                n_p = irc_pkg::ONE_60 - 61'(mul_prod[113:60]);
                if (r_k == K_LAST) begin
                    n_sqn = '0;
                    n_state = S_SQR_MUL;
                end else begin
                    n_k = r_k - 3'd1;
                    n_state = S_HORN_MUL;
                end
            end
            S_SQR_MUL: begin
                n_ma = 64'(r_p);
                n_mb = 64'(r_p);
                n_mstart = 1'b1; n_raw = 1'b1; n_ret = S_SQR_ACC; n_state = S_WAIT;
            end
            S_SQR_ACC: begin
                n_p = w_pnew;
                if (r_sqn == SQR_LAST) begin
                    n_e = w_pnew[60:28];
                    n_state = S_CHN0;
                end else begin
                    n_sqn = r_sqn + 4'd1;
                    n_state = S_SQR_MUL;
                end
            end
            // Channel share.
            S_CHN0: begin
                n_ma = 64'(r_togo); n_mb = 64'(r_in.conductivity);
                n_mstart = 1'b1; n_raw = 1'b0; n_ret = S_CHN1; n_state = S_WAIT;
            end
            S_CHN1: begin
                n_ma = 64'(w_mq); n_mb = 64'(w_part);
                n_mstart = 1'b1; n_raw = 1'b0; n_ret = S_CHN2; n_state = S_WAIT;
            end
            S_CHN2: begin
                n_ma = 64'(w_mq); n_mb = 64'(r_in.flow_weight);
                n_mstart = 1'b1; n_raw = 1'b0; n_ret = S_CHN3; n_state = S_WAIT;
            end
            S_CHN3: begin
                n_ma = 64'(w_mq); n_mb = 64'(r_dtdx);
                n_mstart = 1'b1; n_raw = 1'b0; n_ret = S_CHN4; n_state = S_WAIT;
            end
            S_CHN4: begin
                n_tmp = w_mq;
                n_ma = 64'(r_in.channel_length); n_mb = 64'(r_invcs);
                n_mstart = 1'b1; n_raw = 1'b0; n_ret = S_CHN5; n_state = S_WAIT;
            end
            S_CHN5: begin
                n_ma = 64'(r_tmp); n_mb = 64'(w_mq);
                n_mstart = 1'b1; n_raw = 1'b0; n_ret = S_CHN6; n_state = S_WAIT;
            end
            S_CHN6: begin
                n_chn  = (w_mq > r_togo) ? r_togo : w_mq;
                n_togo = r_togo - ((w_mq > r_togo) ? r_togo : w_mq);
                n_state = S_SIN0;
            end
            // Sine of the slope angle.
            S_SIN0: begin
                if (r_in.slope == '0) begin
                    n_sa = '0;
                    n_state = S_ALP0;
                end else if (r_in.slope <= irc_pkg::ONE_Q) begin
                    n_sbig = 1'b0;
                    n_ma = 64'(r_in.slope); n_mb = 64'(r_in.slope);
                    n_mstart = 1'b1; n_raw = 1'b0; n_ret = S_SIN_Y; n_state = S_WAIT;
                end else begin
                    n_sbig = 1'b1;
                    n_da = {irc_pkg::ONE_Q, 32'd0};
                    n_db = 42'(r_in.slope);
                    n_dstart = 1'b1; n_raw = 1'b0; n_ret = S_SIN_U; n_state = S_WAIT;
                end
            end
            S_SIN_U: begin
                n_ma = 64'(w_dq); n_mb = 64'(w_dq);
                n_mstart = 1'b1; n_raw = 1'b0; n_ret = S_SIN_Y; n_state = S_WAIT;
            end
            S_SIN_Y: begin
                n_sy = 41'(irc_pkg::ONE_Q) + 41'(w_mq);
                n_sstart = 1'b1; n_ret = S_SIN_R; n_state = S_WAIT;
            end
            S_SIN_R: begin
                n_da = {(r_sbig ? irc_pkg::ONE_Q : r_in.slope), 32'd0};
                n_db = 42'(sqrt_root);
                n_dstart = 1'b1; n_raw = 1'b0; n_ret = S_SIN_D; n_state = S_WAIT;
            end
            S_SIN_D: begin
                n_sa = w_dq;
                n_state = S_ALP0;
            end
            // Kinematic downstream share.
            S_ALP0: begin
                n_ma = 64'(r_in.conductivity); n_mb = 64'(r_sa);
                n_mstart = 1'b1; n_raw = 1'b0; n_ret = S_ALP1; n_state = S_WAIT;
            end
            S_ALP1: begin
                n_ma = 64'(w_mq); n_mb = 64'(r_in.flow_weight);
                n_mstart = 1'b1; n_raw = 1'b0; n_ret = S_ALP2; n_state = S_WAIT;
            end
            S_ALP2: begin
                n_alpha = w_mq;
                n_ma = 64'(w_mq); n_mb = 64'(r_dtdx);
                n_mstart = 1'b1; n_raw = 1'b0; n_ret = S_ALP3; n_state = S_WAIT;
            end
            S_ALP3: begin
                n_da = {r_togo, 32'd0};
                n_db = 42'(irc_pkg::ONE_Q) + 42'(w_mq);
                n_dstart = 1'b1; n_raw = 1'b0; n_ret = S_ALP4; n_state = S_WAIT;
            end
            S_ALP4: begin
                n_ma = 64'(w_dq); n_mb = 64'(r_alpha);
                n_mstart = 1'b1; n_raw = 1'b0; n_ret = S_ALP5; n_state = S_WAIT;
            end
            S_ALP5: begin
                n_ma = 64'(w_mq); n_mb = 64'(r_dtdx);
                n_mstart = 1'b1; n_raw = 1'b0; n_ret = S_ALP6; n_state = S_WAIT;
            end
            S_ALP6: begin
                n_down = (w_mq > r_togo) ? r_togo : w_mq;
                n_togo = r_togo - ((w_mq > r_togo) ? r_togo : w_mq);
                n_state = S_THETA0;
            end
            // Refill the soil and split any saturation excess.
            S_THETA0: begin
                n_da = {r_togo, 32'd0};
                n_db = 42'(r_in.layer_depth);
                n_dstart = 1'b1; n_raw = 1'b0; n_ret = S_THETA1; n_state = S_WAIT;
            end
            S_THETA1: begin
                s = f_addq(r_theta, w_dq);
                n_theta = s[39:0];
                n_flag = r_flag | s[40];
                n_state = S_SAT0;
            end
            S_SAT0: begin
                if (r_theta > r_in.saturation) begin
                    n_theta = r_in.saturation;
                    n_ma = 64'(r_theta - r_in.saturation); n_mb = 64'(r_in.layer_depth);
                    n_mstart = 1'b1; n_raw = 1'b0; n_ret = S_SAT1; n_state = S_WAIT;
                end else begin
                    n_state = S_DS0;
                end
            end
            S_SAT1: begin
                n_tmp = w_mq;
                n_ma = 64'(w_mq); n_mb = 64'(r_share);
                n_mstart = 1'b1; n_raw = 1'b0; n_ret = S_SAT2; n_state = S_WAIT;
            end
            S_SAT2: begin
                s = f_addq(r_down, w_mq);
                n_down = s[39:0];
                n_flag = r_flag | s[40];
                n_ma = 64'(r_tmp); n_mb = 64'(irc_pkg::ONE_Q - 40'(r_share));
                n_mstart = 1'b1; n_raw = 1'b0; n_ret = S_SAT3; n_state = S_WAIT;
            end
            S_SAT3: begin
                n_rr = w_mq;
                n_state = S_DS0;
            end
            // Add the downstream flow into the receiver's entry.
            S_DS0:   n_state = w_ds_ok ? S_DS1 : S_FINISH;
            S_DS1: begin
                n_flag = r_flag | w_add[40];
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_out.cell_index     = w_c32[15:0];
                    n_out.new_moisture   = r_theta;
                    n_out.to_channel     = r_chn;
                    n_out.to_downstream  = r_down;
                    n_out.repercolation  = r_rr;
                    n_out.saturated_flag = r_flag;
                    n_cnt   = w_cnext;
                    n_state = S_IDLE;
                end
            end
            S_WAIT: begin
                if (mul_done || div_done || sqrt_done) begin
                    if (!r_raw) n_flag = r_flag | (mul_done & w_mq_ovf) | (div_done & w_dq_ovf);
                    n_state = r_ret;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_mstart <= 1'b0;
            r_dstart <= 1'b0;
            r_sstart <= 1'b0;
            r_dtdx   <= irc_pkg::ONE_Q;
            r_invcs  <= irc_pkg::ONE_Q;
            r_minw   <= 40'd1;
            r_ccount <= 17'd65536;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            r_mstart <= n_mstart;
            r_dstart <= n_dstart;
            r_sstart <= n_sstart;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    irc_pkg::CFG_DT_OVER_DX:    r_dtdx   <= i_cfg_data;
                    irc_pkg::CFG_INV_CELL_SIZE: r_invcs  <= i_cfg_data;
                    irc_pkg::CFG_MIN_WATER:     r_minw   <= i_cfg_data;
                    irc_pkg::CFG_CELL_COUNT:    r_ccount <= i_cfg_data[16:0];
                    default:                    r_minw   <= r_minw;
                endcase
            end
        end
        r_ret <= n_ret;   r_in <= n_in;       r_share <= n_share; r_togo <= n_togo;
        r_theta <= n_theta; r_chn <= n_chn;   r_down <= n_down;   r_rr <= n_rr;
        r_tmp <= n_tmp;   r_alpha <= n_alpha; r_sa <= n_sa;       r_flag <= n_flag;
        r_sbig <= n_sbig; r_raw <= n_raw;     r_e <= n_e;         r_t <= n_t;
        r_p <= n_p;       r_k <= n_k;         r_sqn <= n_sqn;     r_ma <= n_ma;
        r_mb <= n_mb;     r_da <= n_da;       r_db <= n_db;       r_sy <= n_sy;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/irc_checker.sv =====
// Port-level checker for the interflow routing block, bound to the top level.
`include "interflow_routing_cell_step_macros.svh"

module irc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input irc_pkg::t_out o_out_data
);

    // A stalled result stays offered and unchanged.
    `IRC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `IRC_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))

    // One word at a time: an accepted word makes the block busy.
    `IRC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // A new result only appears at the end of work on a word.
    `IRC_ASSERT_IMP(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind interflow_routing_cell_step irc_checker u_irc_checker (.*);
